@@ src/cpi_pkg.sv @@
// Shared constants, types and codes for the CSR pattern insert block.
`timescale 1ns / 1ps

package cpi_pkg;

  // Store sizes
  localparam int MAX_ROWS = 256;
  localparam int CAPACITY = 4096;

  // Field widths of the channels
  localparam int IDX_W    = 9;
  localparam int STS_W    = 3;
  localparam int SLOT_W   = 12;
  localparam int NZ_W     = 13;
  localparam int COL_W    = 9;

  // Derived widths
  localparam int RAW      = $clog2(MAX_ROWS + 1);
  localparam int KW       = RAW + 1;
  localparam int CAW      = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LIM_W    = (RAW > IDX_W) ? RAW : IDX_W;

  localparam logic [IDX_W-1:0] ROWS_RESET = IDX_W'(256);

  typedef enum logic [STS_W-1:0] {
    STS_INSERTED = 3'd0,
    STS_PRESENT  = 3'd1,
    STS_FIXED    = 3'd2,
    STS_RANGE    = 3'd3,
    STS_FULL     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_LO,
    ST_LOAD_HI,
    ST_SEARCH,
    ST_SHIFT,
    ST_PUT,
    ST_PINC,
    ST_EMIT
  } state_e;

  // Row pointer memory request
  typedef struct packed {
    logic             we;
    logic [RAW-1:0]   waddr;
    logic [CNT_W-1:0] wdata;
    logic [RAW-1:0]   raddr;
  } ptr_req_t;

  // Column entry memory request
  typedef struct packed {
    logic             we;
    logic [CAW-1:0]   waddr;
    logic [COL_W-1:0] wdata;
    logic [CAW-1:0]   raddr;
  } col_req_t;

endpackage

@@ src/cpi_if.sv @@
// Channel interfaces: position words in, result words out, register writes.
`timescale 1ns / 1ps

interface cpi_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [8:0]         row;
  logic signed [8:0]         col;

  modport source (output valid, output row, output col, input ready);
  modport sink   (input valid, input row, input col, output ready);
endinterface

interface cpi_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [11:0]               slot;
  logic [12:0]               nonzero_count;

  modport source (output valid, output status, output slot, output nonzero_count,
                  input ready);
  modport sink   (input valid, input status, input slot, input nonzero_count,
                  output ready);
endinterface

interface cpi_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [8:0]                rows_in_use;

  modport source (output valid, output rows_in_use, input ready);
  modport sink   (input valid, input rows_in_use, output ready);
endinterface

@@ src/cpi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/cpi_seq.sv @@
// Sequencer: row pointer lookup, row walk, entry shift and pointer update.
`timescale 1ns / 1ps

module cpi_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cpi_pkg::IDX_W-1:0]    rows_in_use_i,
  cpi_in_if.sink                       in_i,
  cpi_out_if.source                    out_o,
  output cpi_pkg::ptr_req_t            ptr_req_o,
  input  logic [cpi_pkg::CNT_W-1:0]    ptr_rdata_i,
  output cpi_pkg::col_req_t            col_req_o,
  input  logic [cpi_pkg::COL_W-1:0]    col_rdata_i
);

  localparam int RAW   = cpi_pkg::RAW;
  localparam int KW    = cpi_pkg::KW;
  localparam int CAW   = cpi_pkg::CAW;
  localparam int CNT_W = cpi_pkg::CNT_W;
  localparam int LIM_W = cpi_pkg::LIM_W;
  localparam int IDX_W = cpi_pkg::IDX_W;

  cpi_pkg::state_e     state_q, state_d;
  cpi_pkg::status_e    res_sts_q, res_sts_d;
  logic [IDX_W-1:0]    r_q, r_d, c_q, c_d;
  logic [CNT_W-1:0]    lo_q, lo_d, hi_q, hi_d, p_q, p_d, j_q, j_d, count_q, count_d;
  logic [CAW-1:0]      cwa_q, cwa_d;
  logic [RAW-1:0]      pwa_q, pwa_d;
  logic [KW-1:0]       k_q, k_d, clr_q, clr_d;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  cpi_pkg::status_e    out_sts_q, out_sts_d;
  logic [cpi_pkg::SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [cpi_pkg::NZ_W-1:0]   out_nz_q, out_nz_d;

  logic [IDX_W-1:0]    r_in, c_in;
  logic [LIM_W-1:0]    riu_ext, limit;
  logic                accept, is_fixed, is_range;
  logic                walk_on, found, full, shift_on, pinc_on, clr_done, emit_go;

  // Decode the incoming word and the saturated row limit
  assign r_in     = in_i.row;
  assign c_in     = in_i.col;
  assign riu_ext  = LIM_W'(rows_in_use_i);
  assign limit    = (riu_ext > LIM_W'(cpi_pkg::MAX_ROWS)) ?
                    LIM_W'(cpi_pkg::MAX_ROWS) : riu_ext;
  assign accept   = (state_q == cpi_pkg::ST_IDLE) && in_i.valid;
  assign is_fixed = r_in[IDX_W-1] | c_in[IDX_W-1];
  assign is_range = (LIM_W'(r_in) >= limit) || (LIM_W'(c_in) >= limit);

  // Walk and update conditions
  assign walk_on  = (p_q < hi_q) && (col_rdata_i < c_q);
  assign found    = (p_q < hi_q) && (col_rdata_i == c_q);
  assign full     = (count_q >= CNT_W'(cpi_pkg::CAPACITY));
  assign shift_on = (j_q > p_q);
  assign pinc_on  = (k_q <= KW'(cpi_pkg::MAX_ROWS));
  assign clr_done = (clr_q == KW'(cpi_pkg::MAX_ROWS));
  assign emit_go  = !out_valid_q || out_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpi_pkg::ST_CLEAR: begin
        if (clr_done) state_d = cpi_pkg::ST_IDLE;
      end
      cpi_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (is_fixed || is_range) ? cpi_pkg::ST_EMIT : cpi_pkg::ST_LOAD_LO;
        end
      end
      cpi_pkg::ST_LOAD_LO: state_d = cpi_pkg::ST_LOAD_HI;
      cpi_pkg::ST_LOAD_HI: state_d = cpi_pkg::ST_SEARCH;
      cpi_pkg::ST_SEARCH: begin
        if (walk_on) begin
          state_d = cpi_pkg::ST_SEARCH;
        end else if (found || full) begin
          state_d = cpi_pkg::ST_EMIT;
        end else begin
          state_d = cpi_pkg::ST_SHIFT;
        end
      end
      cpi_pkg::ST_SHIFT: begin
        if (!shift_on) state_d = cpi_pkg::ST_PUT;
      end
      cpi_pkg::ST_PUT: state_d = cpi_pkg::ST_PINC;
      cpi_pkg::ST_PINC: begin
        if (!pinc_on) state_d = cpi_pkg::ST_EMIT;
      end
      cpi_pkg::ST_EMIT: begin
        if (emit_go) state_d = cpi_pkg::ST_IDLE;
      end
      default: state_d = cpi_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls, memory requests and register updates
  always_comb begin
    ptr_req_o   = '0;
    col_req_o   = '0;
    in_i.ready  = 1'b0;
    res_sts_d   = res_sts_q;
    r_d         = r_q;
    c_d         = c_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    p_d         = p_q;
    j_d         = j_q;
    count_d     = count_q;
    cwa_d       = cwa_q;
    pwa_d       = pwa_q;
    k_d         = k_q;
    clr_d       = clr_q;
    pend_d      = pend_q;
    out_sts_d   = out_sts_q;
    out_slot_d  = out_slot_q;
    out_nz_d    = out_nz_q;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      // Zero every row pointer after reset
      cpi_pkg::ST_CLEAR: begin
        ptr_req_o.we    = 1'b1;
        ptr_req_o.waddr = clr_q[RAW-1:0];
        ptr_req_o.wdata = '0;
        clr_d           = clr_q + KW'(1);
      end
      // Take a word and fetch the row start pointer
      cpi_pkg::ST_IDLE: begin
        in_i.ready      = 1'b1;
        ptr_req_o.raddr = RAW'(r_in);
        if (accept) begin
          r_d = r_in;
          c_d = c_in;
          p_d = '0;
          if (is_fixed) begin
            res_sts_d = cpi_pkg::STS_FIXED;
          end else begin
            res_sts_d = cpi_pkg::STS_RANGE;
          end
        end
      end
      // Latch the row start, fetch the next row start
      cpi_pkg::ST_LOAD_LO: begin
        lo_d            = ptr_rdata_i;
        ptr_req_o.raddr = RAW'(r_q) + RAW'(1);
      end
      // Latch the row end and read the first entry of the row
      cpi_pkg::ST_LOAD_HI: begin
        hi_d            = ptr_rdata_i;
        p_d             = lo_q;
        col_req_o.raddr = lo_q[CAW-1:0];
      end
      // Advance one entry per cycle while it is below the column
      cpi_pkg::ST_SEARCH: begin
        if (walk_on) begin
          p_d             = p_q + CNT_W'(1);
          col_req_o.raddr = CAW'(p_q + CNT_W'(1));
        end else if (found) begin
          res_sts_d = cpi_pkg::STS_PRESENT;
        end else if (full) begin
          res_sts_d = cpi_pkg::STS_FULL;
          p_d       = '0;
        end else begin
          j_d    = count_q;
          pend_d = 1'b0;
        end
      end
      // Move entries up one slot: read j-1, then write the returned entry to j
      cpi_pkg::ST_SHIFT: begin
        col_req_o.we    = pend_q;
        col_req_o.waddr = cwa_q;
        col_req_o.wdata = col_rdata_i;
        if (shift_on) begin
          col_req_o.raddr = CAW'(j_q - CNT_W'(1));
          cwa_d           = j_q[CAW-1:0];
          pend_d          = 1'b1;
          j_d             = j_q - CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
      end
      // Drop the new column into its slot
      cpi_pkg::ST_PUT: begin
        col_req_o.we    = 1'b1;
        col_req_o.waddr = p_q[CAW-1:0];
        col_req_o.wdata = c_q;
        count_d         = count_q + CNT_W'(1);
        k_d             = KW'(r_q) + KW'(1);
        pend_d          = 1'b0;
      end
      // Increment every following row pointer: read pointer k, write it back plus one next cycle
      cpi_pkg::ST_PINC: begin
        ptr_req_o.we    = pend_q;
        ptr_req_o.waddr = pwa_q;
        ptr_req_o.wdata = ptr_rdata_i + CNT_W'(1);
        if (pinc_on) begin
          ptr_req_o.raddr = k_q[RAW-1:0];
          pwa_d           = k_q[RAW-1:0];
          pend_d          = 1'b1;
          k_d             = k_q + KW'(1);
        end else begin
          pend_d    = 1'b0;
          res_sts_d = cpi_pkg::STS_INSERTED;
        end
      end
      // Hand the result word to the output register once it is free
      cpi_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          out_sts_d   = res_sts_q;
          out_slot_d  = cpi_pkg::SLOT_W'(p_q);
          out_nz_d    = cpi_pkg::NZ_W'(count_q);
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpi_pkg::ST_CLEAR;
      count_q     <= '0;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_sts_q  <= res_sts_d;
    r_q        <= r_d;
    c_q        <= c_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    p_q        <= p_d;
    j_q        <= j_d;
    cwa_q      <= cwa_d;
    pwa_q      <= pwa_d;
    k_q        <= k_d;
    out_sts_q  <= out_sts_d;
    out_slot_q <= out_slot_d;
    out_nz_q   <= out_nz_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_sts_q;
  assign out_o.slot          = out_slot_q;
  assign out_o.nonzero_count = out_nz_q;

endmodule

@@ src/csr_pattern_insert_top.sv @@
// Top level of the CSR pattern insert block: register, memories, sequencer.
//
// Keeps the nonzero pattern of a square sparse matrix in CSR form. Each word on
// in_i names a (row, col) position; each produces exactly one word on out_o with
// a status (inserted, already present, fixed skipped, out of range, full), the
// slot of the column entry and the stored nonzero count after the item.
// cfg_i writes rows_in_use (saturates at MAX_ROWS); write it only while idle.
// One item is in flight at a time; in_i.ready is high only in the idle state.
// Fixed and out-of-range words skip the store: they go from the idle state to
// the emit state and then into the output register. An item that reaches the
// store walks its row from row_start; a new column shifts later entries up one
// slot and bumps the pointers of all following rows. The walk and the shift share
// the single read port of the column memory, one entry a cycle; the pointer
// update goes through the row pointer memory one row a cycle. After reset all
// MAX_ROWS + 1 = 257 row pointers are cleared before the first word is taken;
// config writes are taken meanwhile.
// The result sits in an output register; a stalled receiver holds it, and a
// following item may be accepted and worked on, waiting only to hand over.
`timescale 1ns / 1ps

module csr_pattern_insert_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpi_cfg_if.sink    cfg_i,
  cpi_in_if.sink     in_i,
  cpi_out_if.source  out_o
);

  logic [cpi_pkg::IDX_W-1:0] rows_in_use_q;
  cpi_pkg::ptr_req_t         ptr_req;
  cpi_pkg::col_req_t         col_req;
  logic [cpi_pkg::CNT_W-1:0] ptr_rdata;
  logic [cpi_pkg::COL_W-1:0] col_rdata;

  // Hold the row limit register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_in_use_q <= cpi_pkg::ROWS_RESET;
    end else if (cfg_i.valid) begin
      rows_in_use_q <= cfg_i.rows_in_use;
    end
  end

  cpi_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rows_in_use_i (rows_in_use_q),
    .in_i          (in_i),
    .out_o         (out_o),
    .ptr_req_o     (ptr_req),
    .ptr_rdata_i   (ptr_rdata),
    .col_req_o     (col_req),
    .col_rdata_i   (col_rdata)
  );

  // Zero-based row start pointers
  cpi_ram #(
    .WIDTH (cpi_pkg::CNT_W),
    .DEPTH (cpi_pkg::MAX_ROWS + 1)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ptr_req.we),
    .waddr_i (ptr_req.waddr),
    .wdata_i (ptr_req.wdata),
    .raddr_i (ptr_req.raddr),
    .rdata_o (ptr_rdata)
  );

  // Sorted column entries
  cpi_ram #(
    .WIDTH (cpi_pkg::COL_W),
    .DEPTH (cpi_pkg::CAPACITY)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_req.we),
    .waddr_i (col_req.waddr),
    .wdata_i (col_req.wdata),
    .raddr_i (col_req.raddr),
    .rdata_o (col_rdata)
  );

endmodule

@@ src/cpi_checker.sv @@
// Port-level checker for the CSR pattern insert block, bound to the top level.
`timescale 1ns / 1ps

module cpi_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [cpi_pkg::STS_W-1:0]    status_i,
  input logic [cpi_pkg::SLOT_W-1:0]   slot_i,
  input logic [cpi_pkg::NZ_W-1:0]     nz_i
);

  logic [cpi_pkg::NZ_W-1:0] last_nz_q;

  // Track the count of the last delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_nz_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      last_nz_q <= nz_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(slot_i) && $stable(nz_i))
    else $error("result word changed while stalled");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == cpi_pkg::STS_FIXED || status_i == cpi_pkg::STS_RANGE ||
      status_i == cpi_pkg::STS_FULL) |-> slot_i == '0)
    else $error("nonzero slot on a rejected word");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == cpi_pkg::STS_INSERTED |->
      nz_i == last_nz_q + cpi_pkg::NZ_W'(1))
    else $error("insert did not grow the count by one");

  a_count_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != cpi_pkg::STS_INSERTED |-> nz_i == last_nz_q)
    else $error("count changed without an insert");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> nz_i <= cpi_pkg::NZ_W'(cpi_pkg::CAPACITY))
    else $error("count beyond capacity");

endmodule

bind csr_pattern_insert_top cpi_checker u_cpi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .slot_i      (out_o.slot),
  .nz_i        (out_o.nonzero_count)
);

@@ test/csr_pattern_insert_checker.sv @@
// Checker for the CSR pattern insert block: predicts every result word and compares it.
`timescale 1ns / 1ps

module csr_pattern_insert_checker
  import cpi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cpi_cfg_if   cfg_i,
  cpi_in_if    pos_i,
  cpi_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   inserted_o,
  output int   present_o,
  output int   fixed_o,
  output int   range_o,
  output int   full_o
);

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [NZ_W-1:0]   nonzeros;
  } placement_t;

  // Expected result words, oldest first
  placement_t       awaited_results [$];

  // Shadow copy of the pattern and the row limit register
  int unsigned      row_ptr_shadow [0:MAX_ROWS];
  logic [COL_W-1:0] col_shadow [0:CAPACITY-1];
  logic [IDX_W-1:0] rows_shadow;

  int mismatches = 0;
  int tally [5];

  function automatic int unsigned stored_total();
    int unsigned n;
    n = row_ptr_shadow[MAX_ROWS] - 1;
    return (n > CAPACITY) ? CAPACITY : n;
  endfunction

  // Place one (row, col) position in the shadow pattern and return its result word
  function automatic placement_t place_position(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    placement_t  res;
    int unsigned lim, used, lo, hi, p, j;
    lim = (rows_shadow > MAX_ROWS) ? MAX_ROWS : rows_shadow;
    res.status = STS_INSERTED;
    res.slot = '0;
    if (r[IDX_W-1] || c[IDX_W-1]) begin
      res.status = STS_FIXED;
    end else if (r >= lim || c >= lim) begin
      res.status = STS_RANGE;
    end else begin
      used = stored_total();
      lo = row_ptr_shadow[r] - 1;
      hi = row_ptr_shadow[r + 1] - 1;
      if (hi > used) hi = used;
      if (lo > hi) lo = hi;
      // Walk the row up to the first column not below c
      p = lo;
      while (p < hi && col_shadow[p] < c) p++;
      if (p < hi && col_shadow[p] == c) begin
        res.status = STS_PRESENT;
        res.slot = SLOT_W'(p);
      end else if (used >= CAPACITY) begin
        res.status = STS_FULL;
      end else begin
        // Shift later columns up, drop c in, bump every following row pointer
        for (j = used; j > p; j--) col_shadow[j] = col_shadow[j - 1];
        col_shadow[p] = c;
        for (j = r + 1; j <= MAX_ROWS; j++) row_ptr_shadow[j]++;
        res.slot = SLOT_W'(p);
      end
    end
    res.nonzeros = NZ_W'(stored_total());
    return res;
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] MISMATCH %s", $time, what);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    placement_t want;
    int         i;
    if (!rst_ni) begin
      awaited_results.delete();
      rows_shadow = ROWS_RESET;
      for (i = 0; i <= MAX_ROWS; i++) row_ptr_shadow[i] = 1;
      for (i = 0; i < CAPACITY; i++) col_shadow[i] = '0;
      for (i = 0; i < 5; i++) tally[i] = 0;
    end else begin
      // Match a delivered word against the oldest expectation
      if (res_i.valid && res_i.ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("result word with nothing awaited: status %0d slot %0d nonzeros %0d",
                                  res_i.status, res_i.slot, res_i.nonzero_count));
        end else begin
          want = awaited_results.pop_front();
          if (res_i.status !== want.status || res_i.slot !== want.slot ||
              res_i.nonzero_count !== want.nonzeros) begin
            flag_mismatch($sformatf(
              "status %0d/%0d slot %0d/%0d nonzeros %0d/%0d (expected/actual)",
              want.status, res_i.status, want.slot, res_i.slot,
              want.nonzeros, res_i.nonzero_count));
          end
        end
      end
      // Track the row limit register
      if (cfg_i.valid && cfg_i.ready) rows_shadow = cfg_i.rows_in_use;
      // Predict the word for each accepted position
      if (pos_i.valid && pos_i.ready) begin
        want = place_position(pos_i.row, pos_i.col);
        awaited_results.push_back(want);
        tally[want.status]++;
      end
    end
    pending_o    = awaited_results.size();
    fail_count_o = mismatches;
    inserted_o   = tally[STS_INSERTED];
    present_o    = tally[STS_PRESENT];
    fixed_o      = tally[STS_FIXED];
    range_o      = tally[STS_RANGE];
    full_o       = tally[STS_FULL];
  end

endmodule

@@ test/csr_pattern_insert_top_tb.sv @@
// Testbench top for the CSR pattern insert block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module csr_pattern_insert_top_tb;
  import cpi_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 50;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic hold_done = 1'b0;
  int   results_taken = 0;
  int   eff_rows;
  int   fail_count, pending, n_inserted, n_present, n_fixed, n_range, n_full;

  // In-range positions sent so far, replayed to hit stored entries
  logic [2*IDX_W-1:0] placed_q [$];

  cpi_cfg_if cfg_w ();
  cpi_in_if  pos_w ();
  cpi_out_if res_w ();

  csr_pattern_insert_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_w),
    .in_i   (pos_w),
    .out_o  (res_w)
  );

  csr_pattern_insert_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_w),
    .pos_i        (pos_w),
    .res_i        (res_w),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .inserted_o   (n_inserted),
    .present_o    (n_present),
    .fixed_o      (n_fixed),
    .range_o      (n_range),
    .full_o       (n_full)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (res_w.valid && res_w.ready) results_taken <= results_taken + 1;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // Receiver: random stalls, one long hold once results are flowing
  initial begin
    int gap;
    res_w.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        res_w.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        gap = pick_gap();
        res_w.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        res_w.ready <= 1'b1;
      end
    end
  end

  // Offer one position word and hold it until taken
  task automatic send_pos(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
    int gap;
    @(negedge clk_i);
    gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      pos_w.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pos_w.valid <= 1'b1;
    pos_w.row   <= r;
    pos_w.col   <= c;
    do @(posedge clk_i); while (!pos_w.ready);
  endtask

  // Drop valid and wait until every awaited word has come back
  task automatic settle();
    @(negedge clk_i);
    pos_w.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_rows(input logic [IDX_W-1:0] v);
    settle();
    cfg_w.valid       <= 1'b1;
    cfg_w.rows_in_use <= v;
    do @(posedge clk_i); while (!cfg_w.ready);
    @(negedge clk_i);
    cfg_w.valid <= 1'b0;
    eff_rows = (v > MAX_ROWS) ? MAX_ROWS : v;
  endtask

  // Mostly in-range positions, then repeats, skipped dofs and raw noise
  task automatic send_random();
    logic [IDX_W-1:0] r, c;
    int               pick, k;
    pick = $urandom_range(0, 99);
    if (pick < 60 && eff_rows > 0) begin
      r = IDX_W'($urandom_range(0, eff_rows - 1));
      c = IDX_W'($urandom_range(0, eff_rows - 1));
    end else if (pick < 75 && placed_q.size() > 0) begin
      k = $urandom_range(0, placed_q.size() - 1);
      {r, c} = placed_q[k];
    end else begin
      r = IDX_W'($urandom);
      c = IDX_W'($urandom);
      if (pick < 85) begin
        case ($urandom_range(0, 2))
          0:       r[IDX_W-1] = 1'b1;
          1:       c[IDX_W-1] = 1'b1;
          default: begin
            r[IDX_W-1] = 1'b1;
            c[IDX_W-1] = 1'b1;
          end
        endcase
      end
    end
    if (!r[IDX_W-1] && !c[IDX_W-1] && r < eff_rows && c < eff_rows) placed_q.push_back({r, c});
    send_pos(r, c);
  endtask

  initial begin
    cfg_w.valid       = 1'b0;
    cfg_w.rows_in_use = ROWS_RESET;
    pos_w.valid       = 1'b0;
    pos_w.row         = '0;
    pos_w.col         = '0;
    eff_rows          = MAX_ROWS;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, sorted placement, repeats, skipped dofs (hex 1FF is -1, 100 is -256)
    send_pos(9'd0, 9'd0);
    send_pos(9'd0, 9'd0);
    send_pos(9'd255, 9'd255);
    send_pos(9'd255, 9'd0);
    send_pos(9'd0, 9'd255);
    send_pos(9'd128, 9'd64);
    send_pos(9'd128, 9'd10);
    send_pos(9'd128, 9'd200);
    send_pos(9'd128, 9'd64);
    send_pos(9'h1FF, 9'd5);
    send_pos(9'd7, 9'h100);
    send_pos(9'h100, 9'h1FF);
    send_pos(9'h1FF, 9'd255);
    // Small matrix: out of range on either index, skip wins over range
    write_rows(9'd10);
    send_pos(9'd10, 9'd3);
    send_pos(9'd3, 9'd10);
    send_pos(9'd9, 9'd9);
    send_pos(9'h1FB, 9'd20);
    // Zero rows puts everything out of range
    write_rows(9'd0);
    send_pos(9'd0, 9'd0);
    // Register above the row count saturates
    write_rows(9'h1FF);
    send_pos(9'd255, 9'd255);
    send_pos(9'd0, 9'd128);
    // Single row
    write_rows(9'd1);
    send_pos(9'd0, 9'd0);
    send_pos(9'd0, 9'd1);
    send_pos(9'd1, 9'd0);

    // Random phases over several row limits
    write_rows(9'd256);
    repeat (24) send_random();
    write_rows(IDX_W'($urandom_range(2, 40)));
    repeat (24) send_random();
    write_rows(IDX_W'($urandom_range(100, 255)));
    repeat (24) send_random();
    write_rows(9'd300);
    repeat (24) send_random();
    write_rows(9'd256);
    repeat (12) send_random();

    settle();
    repeat (100) @(negedge clk_i);
    $display("Covered %0d position words over row limits 0, 1, 10, 256, 511 and random ones,",
             n_inserted + n_present + n_fixed + n_range + n_full);
    $display("with one long receiver hold: %0d inserted, %0d present, %0d fixed, %0d range, %0d full.",
             n_inserted, n_present, n_fixed, n_range, n_full);
    if (fail_count == 0) begin
      $display("csr_pattern_insert_top verification clean");
    end else begin
      $display("csr_pattern_insert_top verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("csr_pattern_insert_top verification failed");
    $finish;
  end

endmodule
